FILE: hdl/rwcs_pkg.sv
// ----------------------------------------------------------------------------
// rwcs_pkg
// Shared types and codes for the radio wake cycle sequencer.
// ----------------------------------------------------------------------------
package rwcs_pkg;

   localparam int TIME_W  = 32;
   localparam int LEN_W   = 20;
   localparam int BYTES_W = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 20;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ADVERTISE_TIME  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCK_CAP_TIME   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WATCH_TIME      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SAFE_DEADLINE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RADIO_BYTES = 3'd4;

   // defaults, also used while a register holds zero
   localparam logic [LEN_W-1:0]   DFLT_ADVERTISE_TIME  = 20'd3000;
   localparam logic [LEN_W-1:0]   DFLT_LOCK_CAP_TIME   = 20'd12000;
   localparam logic [LEN_W-1:0]   DFLT_WATCH_TIME      = 20'd20000;
   localparam logic [LEN_W-1:0]   DFLT_SAFE_DEADLINE   = 20'd25000;
   localparam logic [BYTES_W-1:0] DFLT_MIN_RADIO_BYTES = 16'd13226;

   // event kinds
   localparam logic [2:0] KIND_POLL     = 3'd0;
   localparam logic [2:0] KIND_START    = 3'd1;
   localparam logic [2:0] KIND_STOP     = 3'd2;
   localparam logic [2:0] KIND_HOLD_ON  = 3'd3;
   localparam logic [2:0] KIND_HOLD_OFF = 3'd4;

   // error codes
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_ADV_FAIL   = 2'd1;
   localparam logic [1:0] ERR_ADV_SILENT = 2'd2;
   localparam logic [1:0] ERR_LINK_FAIL  = 2'd3;

   // log events
   localparam logic [2:0] LOG_NONE         = 3'd0;
   localparam logic [2:0] LOG_ADV          = 3'd1;
   localparam logic [2:0] LOG_LOCKING      = 3'd2;
   localparam logic [2:0] LOG_LOCKED       = 3'd3;
   localparam logic [2:0] LOG_CAPPED       = 3'd4;
   localparam logic [2:0] LOG_CLOSED_SAFE  = 3'd5;
   localparam logic [2:0] LOG_CLOSED_WATCH = 3'd6;

   typedef enum logic [2:0] {
      PH_OFF      = 3'd0,
      PH_WAKING   = 3'd1,
      PH_LOCKING  = 3'd2,
      PH_WATCHING = 3'd3,
      PH_CLOSING  = 3'd4
   } phase_type;

   // effective register values (zero already replaced by the default)
   typedef struct packed {
      logic [LEN_W-1:0]   advertise_time;
      logic [LEN_W-1:0]   lock_cap_time;
      logic [LEN_W-1:0]   watch_time;
      logic [LEN_W-1:0]   safe_deadline;
      logic [BYTES_W-1:0] min_radio_bytes;
   } cfg_type;

   typedef struct packed {
      logic [2:0]        kind;
      logic [TIME_W-1:0] now_time;
      logic              adv_start_ok;
      logic [TIME_W-1:0] adv_bytes_taken;
      logic [TIME_W-1:0] heap_remaining;
      logic              link_start_ok;
      logic              peer_locked;
   } item_type;

   typedef struct packed {
      logic [2:0]        phase_now;
      logic [1:0]        error_code;
      logic [LEN_W-1:0]  time_left;
      logic              adv_start_strobe;
      logic              adv_stop_strobe;
      logic              link_start_strobe;
      logic              link_stop_strobe;
      logic [2:0]        log_event;
      logic [TIME_W-1:0] log_first;
      logic [TIME_W-1:0] log_second;
   } result_type;

endpackage

FILE: hdl/rwcs_csr.sv
// ----------------------------------------------------------------------------
// rwcs_csr
// Configuration registers; presents effective values with zero mapped to
// the default.
// ----------------------------------------------------------------------------
module rwcs_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [rwcs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rwcs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output rwcs_pkg::cfg_type                cfg
);
   import rwcs_pkg::*;

   logic [LEN_W-1:0]   adv_time_ff;
   logic [LEN_W-1:0]   lock_cap_ff;
   logic [LEN_W-1:0]   watch_time_ff;
   logic [LEN_W-1:0]   safe_dl_ff;
   logic [BYTES_W-1:0] min_bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         adv_time_ff   <= DFLT_ADVERTISE_TIME;
         lock_cap_ff   <= DFLT_LOCK_CAP_TIME;
         watch_time_ff <= DFLT_WATCH_TIME;
         safe_dl_ff    <= DFLT_SAFE_DEADLINE;
         min_bytes_ff  <= DFLT_MIN_RADIO_BYTES;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ADVERTISE_TIME:  adv_time_ff   <= csr_wdata;
            CSR_LOCK_CAP_TIME:   lock_cap_ff   <= csr_wdata;
            CSR_WATCH_TIME:      watch_time_ff <= csr_wdata;
            CSR_SAFE_DEADLINE:   safe_dl_ff    <= csr_wdata;
            CSR_MIN_RADIO_BYTES: min_bytes_ff  <= csr_wdata[BYTES_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.advertise_time  = (adv_time_ff   != '0) ? adv_time_ff   : DFLT_ADVERTISE_TIME;
      cfg.lock_cap_time   = (lock_cap_ff   != '0) ? lock_cap_ff   : DFLT_LOCK_CAP_TIME;
      cfg.watch_time      = (watch_time_ff != '0) ? watch_time_ff : DFLT_WATCH_TIME;
      cfg.safe_deadline   = (safe_dl_ff    != '0) ? safe_dl_ff    : DFLT_SAFE_DEADLINE;
      cfg.min_radio_bytes = (min_bytes_ff  != '0) ? min_bytes_ff  : DFLT_MIN_RADIO_BYTES;
   end

endmodule

FILE: hdl/rwcs_core.sv
// ----------------------------------------------------------------------------
// rwcs_core
// Phase state and the single-pass event logic: next state and the result
// item for the event held in the input register.
// ----------------------------------------------------------------------------
module rwcs_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  rwcs_pkg::item_type    item,
   input  rwcs_pkg::cfg_type     cfg,
   output rwcs_pkg::result_type  result
);
   import rwcs_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [TIME_W-1:0] start_ff, start_in;
   logic              hold_ff, hold_in;
   logic              adv_up_ff, adv_up_in;
   logic              link_up_ff, link_up_in;
   logic [TIME_W-1:0] stop_at_ff, stop_at_in;
   logic [TIME_W-1:0] lock_at_ff, lock_at_in;
   logic [TIME_W-1:0] watch_at_ff, watch_at_in;
   logic [1:0]        err_ff, err_in;

   logic [TIME_W-1:0] now;
   logic [TIME_W-1:0] el_old;
   logic [TIME_W-1:0] el_new;
   logic [TIME_W-1:0] since;
   logic [TIME_W-1:0] adv_len;
   logic [TIME_W-1:0] safe;
   logic [TIME_W-1:0] len_old;
   logic [TIME_W-1:0] len_new;
   logic [TIME_W-1:0] left;
   logic [TIME_W-1:0] safe_left;
   logic              due;
   logic              safe_due;

   function automatic logic [TIME_W-1:0] phase_span(input phase_type ph, input cfg_type c);
      logic [TIME_W-1:0] len;
      len = '0;
      unique case (ph)
         PH_WAKING:   len = {{(TIME_W-LEN_W){1'b0}}, c.advertise_time};
         PH_LOCKING:  len = {{(TIME_W-LEN_W){1'b0}}, c.lock_cap_time};
         PH_WATCHING: len = {{(TIME_W-LEN_W){1'b0}}, c.watch_time};
         default:     len = '0;
      endcase
      return len;
   endfunction

   assign now      = item.now_time;
   assign adv_len  = {{(TIME_W-LEN_W){1'b0}}, cfg.advertise_time};
   assign safe     = {{(TIME_W-LEN_W){1'b0}}, cfg.safe_deadline};
   assign el_old   = now - start_ff;
   assign since    = now - stop_at_ff;
   assign len_old  = phase_span(phase_ff, cfg);
   assign due      = el_old >= len_old;
   assign safe_due = since >= safe;

   always_comb begin
      phase_in    = phase_ff;
      start_in    = start_ff;
      hold_in     = hold_ff;
      adv_up_in   = adv_up_ff;
      link_up_in  = link_up_ff;
      stop_at_in  = stop_at_ff;
      lock_at_in  = lock_at_ff;
      watch_at_in = watch_at_ff;
      err_in      = err_ff;
      el_new      = el_old;
      result      = '0;

      case (item.kind)
         KIND_START: begin
            hold_in    = 1'b0;
            adv_up_in  = 1'b0;
            link_up_in = 1'b0;
            phase_in   = PH_WAKING;
            start_in   = now - adv_len;
            el_new     = adv_len;
         end
         KIND_STOP: begin
            result.adv_stop_strobe  = adv_up_ff;
            result.link_stop_strobe = link_up_ff;
            adv_up_in  = 1'b0;
            link_up_in = 1'b0;
            phase_in   = PH_OFF;
            hold_in    = 1'b0;
         end
         KIND_HOLD_ON:  hold_in = 1'b1;
         KIND_HOLD_OFF: hold_in = 1'b0;
         KIND_POLL: begin
            unique case (phase_ff)
               PH_WAKING: begin
                  if (!adv_up_ff) begin
                     start_in = now;
                     el_new   = '0;
                     if (!item.adv_start_ok) begin
                        err_in = ERR_ADV_FAIL;
                     end else begin
                        result.adv_start_strobe = 1'b1;
                        result.log_event        = LOG_ADV;
                        result.log_first        = item.adv_bytes_taken;
                        result.log_second       = item.heap_remaining;
                        if (item.adv_bytes_taken <
                            {{(TIME_W-BYTES_W){1'b0}}, cfg.min_radio_bytes}) begin
                           // silent advertiser: release it right away
                           err_in                 = ERR_ADV_SILENT;
                           result.adv_stop_strobe = 1'b1;
                        end else begin
                           err_in    = ERR_NONE;
                           adv_up_in = 1'b1;
                        end
                     end
                  end else if (due) begin
                     result.adv_stop_strobe   = 1'b1;
                     result.link_start_strobe = 1'b1;
                     adv_up_in  = 1'b0;
                     stop_at_in = now;
                     start_in   = now;
                     el_new     = '0;
                     if (!item.link_start_ok) begin
                        err_in = ERR_LINK_FAIL;
                     end else begin
                        err_in           = ERR_NONE;
                        link_up_in       = 1'b1;
                        lock_at_in       = now;
                        result.log_event = LOG_LOCKING;
                        phase_in         = PH_LOCKING;
                     end
                  end
               end
               PH_LOCKING: begin
                  if (item.peer_locked || due) begin
                     result.log_event  = item.peer_locked ? LOG_LOCKED : LOG_CAPPED;
                     result.log_first  = now - lock_at_ff;
                     result.log_second = since;
                     watch_at_in = now;
                     phase_in    = PH_WATCHING;
                     start_in    = now;
                     el_new      = '0;
                  end
               end
               PH_WATCHING: begin
                  if (hold_ff) begin
                     // restart the watch count while held
                     start_in = now;
                     el_new   = '0;
                  end else if (safe_due || due) begin
                     result.log_event  = safe_due ? LOG_CLOSED_SAFE : LOG_CLOSED_WATCH;
                     result.log_first  = now - watch_at_ff;
                     result.log_second = since;
                     phase_in = PH_CLOSING;
                     start_in = now;
                     el_new   = '0;
                  end
               end
               PH_CLOSING: begin
                  result.link_stop_strobe = link_up_ff;
                  link_up_in = 1'b0;
                  phase_in   = PH_WAKING;
                  start_in   = now - adv_len;
                  el_new     = adv_len;
               end
               PH_OFF: ;
               default: ;
            endcase
         end
         default: ;
      endcase

      // remaining time in the phase after this event
      len_new   = phase_span(phase_in, cfg);
      left      = (el_new >= len_new) ? '0 : (len_new - el_new);
      safe_left = safe_due ? '0 : (safe - since);
      if ((phase_in == PH_WATCHING) && (safe_left < left)) begin
         left = safe_left;
      end

      result.phase_now  = phase_in;
      result.error_code = err_in;
      result.time_left  = left[LEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_OFF;
         start_ff    <= '0;
         hold_ff     <= 1'b0;
         adv_up_ff   <= 1'b0;
         link_up_ff  <= 1'b0;
         stop_at_ff  <= '0;
         lock_at_ff  <= '0;
         watch_at_ff <= '0;
         err_ff      <= ERR_NONE;
      end else if (fire) begin
         phase_ff    <= phase_in;
         start_ff    <= start_in;
         hold_ff     <= hold_in;
         adv_up_ff   <= adv_up_in;
         link_up_ff  <= link_up_in;
         stop_at_ff  <= stop_at_in;
         lock_at_ff  <= lock_at_in;
         watch_at_ff <= watch_at_in;
         err_ff      <= err_in;
      end
   end

endmodule

FILE: hdl/radio_wake_cycle_sequencer_unit.sv
// ----------------------------------------------------------------------------
// radio_wake_cycle_sequencer_unit
// Duty-cycle sequencer for an advertiser and a peer link radio: off, waking,
// locking, watching, closing. One result transaction per event transaction.
//
//   channel | ports        | direction | carries
//   req     | req_*        | in        | event kind, time, radio start outcomes
//   rsp     | rsp_*        | out       | phase, error, time left, strobes, log
//   csr     | csr_*        | in        | register writes, no read-back
//
// An event is registered on acceptance, evaluated in one pass against the
// phase state, and its result registered; one event per cycle while the
// result is not stalled. The phase state loop closes in that single pass.
// Reset clears the phase state and restores register defaults.
// A stalled result holds; the input register keeps taking events while the
// result register is free or being drained.
// ----------------------------------------------------------------------------
module radio_wake_cycle_sequencer_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [2:0]                       req_kind,
   input  logic [31:0]                      req_now_time,
   input  logic                             req_adv_start_ok,
   input  logic [31:0]                      req_adv_bytes_taken,
   input  logic [31:0]                      req_heap_remaining,
   input  logic                             req_link_start_ok,
   input  logic                             req_peer_locked,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [2:0]                       rsp_phase_now,
   output logic [1:0]                       rsp_error_code,
   output logic [19:0]                      rsp_time_left,
   output logic                             rsp_adv_start_strobe,
   output logic                             rsp_adv_stop_strobe,
   output logic                             rsp_link_start_strobe,
   output logic                             rsp_link_stop_strobe,
   output logic [2:0]                       rsp_log_event,
   output logic [31:0]                      rsp_log_first,
   output logic [31:0]                      rsp_log_second,
   input  logic                             csr_wr_en,
   input  logic [rwcs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rwcs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rwcs_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   logic       in_valid_ff;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       fire;
   logic       req_take;

   rwcs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rwcs_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // advance the held event whenever the result register can take it
   assign fire      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.kind            <= req_kind;
         item_ff.now_time        <= req_now_time;
         item_ff.adv_start_ok    <= req_adv_start_ok;
         item_ff.adv_bytes_taken <= req_adv_bytes_taken;
         item_ff.heap_remaining  <= req_heap_remaining;
         item_ff.link_start_ok   <= req_link_start_ok;
         item_ff.peer_locked     <= req_peer_locked;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_phase_now         = rsp_ff.phase_now;
   assign rsp_error_code        = rsp_ff.error_code;
   assign rsp_time_left         = rsp_ff.time_left;
   assign rsp_adv_start_strobe  = rsp_ff.adv_start_strobe;
   assign rsp_adv_stop_strobe   = rsp_ff.adv_stop_strobe;
   assign rsp_link_start_strobe = rsp_ff.link_start_strobe;
   assign rsp_link_stop_strobe  = rsp_ff.link_stop_strobe;
   assign rsp_log_event         = rsp_ff.log_event;
   assign rsp_log_first         = rsp_ff.log_first;
   assign rsp_log_second        = rsp_ff.log_second;

   a_log_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_log_event == LOG_NONE) |-> (rsp_log_first == '0) &&
      (rsp_log_second == '0))
      else $error("log numbers set without a log event");

   a_adv_start_logged: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_adv_start_strobe |-> (rsp_log_event == LOG_ADV) &&
      (rsp_phase_now == PH_WAKING))
      else $error("advertiser start without adv log in waking");

   a_idle_no_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_phase_now == PH_OFF) || (rsp_phase_now == PH_CLOSING)) |->
      (rsp_time_left == '0))
      else $error("time left reported in off or closing");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff)
      else $error("input stalled while result register free");

   a_locking_link_started: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_log_event == LOG_LOCKING) |-> rsp_link_start_strobe &&
      rsp_adv_stop_strobe && (rsp_error_code == ERR_NONE))
      else $error("locking entered without link start and advert stop");

endmodule

FILE: dv/radio_wake_cycle_sequencer_unit_tb.sv
// ----------------------------------------------------------------------------
// radio_wake_cycle_sequencer_unit_tb
// Self-checking bench for the radio wake duty-cycle sequencer. A scripted
// opening walks the phases by hand under the reset settings; random event
// streams then run under several register settings, with time advanced in
// steps scaled to the phase in progress. Every response is compared field by
// field against a scripted expectation or an in-bench phase machine model.
// ----------------------------------------------------------------------------
module radio_wake_cycle_sequencer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rwcs_pkg::*;

   localparam int PERIOD             = 10;
   localparam int IDLE_LIMIT         = 400;
   localparam int SETTINGS_RUNS      = 6;
   localparam int EVENTS_PER_SETTING = 210;
   localparam int SCRIPT_LEN         = 27;

   localparam logic [2:0]           KIND_RESERVED_LO = 3'd5;
   localparam logic [2:0]           KIND_RESERVED_HI = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam logic [19:0]          LEN_MAX          = 20'd600000;

   typedef struct {
      item_type   ev;
      bit         has_want;
      result_type want;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_kind;
   logic [31:0] req_now_time;
   logic        req_adv_start_ok;
   logic [31:0] req_adv_bytes_taken;
   logic [31:0] req_heap_remaining;
   logic        req_link_start_ok;
   logic        req_peer_locked;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_phase_now;
   logic [1:0]  rsp_error_code;
   logic [19:0] rsp_time_left;
   logic        rsp_adv_start_strobe;
   logic        rsp_adv_stop_strobe;
   logic        rsp_link_start_strobe;
   logic        rsp_link_stop_strobe;
   logic [2:0]  rsp_log_event;
   logic [31:0] rsp_log_first;
   logic [31:0] rsp_log_second;
   logic        csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   radio_wake_cycle_sequencer_unit uut (.*);

   always #(PERIOD / 2) clock = ~clock;

   // register copies, raw as written (zero means default)
   logic [31:0] cfg_adv   = {12'd0, DFLT_ADVERTISE_TIME};
   logic [31:0] cfg_lock  = {12'd0, DFLT_LOCK_CAP_TIME};
   logic [31:0] cfg_watch = {12'd0, DFLT_WATCH_TIME};
   logic [31:0] cfg_safe  = {12'd0, DFLT_SAFE_DEADLINE};
   logic [31:0] cfg_min   = {16'd0, DFLT_MIN_RADIO_BYTES};

   // phase machine state
   phase_type   ph          = PH_OFF;
   logic [31:0] ph_start    = '0;
   logic [31:0] adv_stop_at = '0;
   logic [31:0] lock_at     = '0;
   logic [31:0] watch_at    = '0;
   bit          hold        = 1'b0;
   bit          adv_on      = 1'b0;
   bit          link_on     = 1'b0;
   logic [1:0]  err         = ERR_NONE;

   result_type  pending_results [$];
   logic [31:0] ms_now;
   bit          quiet       = 1'b0;
   int          gap_pct     = 30;
   int          mismatches  = 0;
   int          events_sent = 0;
   int          results_checked = 0;
   int          settings_used = 1;
   int          log_seen [8] = '{default: 0};
   int          idle_cycles = 0;
   int          stall_left  = 0;
   int          calm_left   = 0;

   script_row_type script [SCRIPT_LEN] = '{
      '{'{KIND_POLL, 32'd0, 1'b0, 32'd0, 32'd0, 1'b0, 1'b0}, 1'b1, '0},
      '{'{KIND_RESERVED_HI, 32'd5, 1'b1, 32'd0, 32'd0, 1'b1, 1'b1}, 1'b1, '0},
      '{'{KIND_HOLD_ON, 32'd10, 1'b0, 32'd0, 32'd0, 1'b0, 1'b0}, 1'b1, '0},
      '{'{KIND_STOP, 32'd20, 1'b0, 32'd0, 32'd0, 1'b0, 1'b0}, 1'b1, '0},
      '{'{KIND_START, 32'd1000, 1'b1, 32'd0, 32'd0, 1'b1, 1'b0}, 1'b1,
        '{PH_WAKING, ERR_NONE, 20'd0, 1'b0, 1'b0, 1'b0, 1'b0, LOG_NONE, 32'd0, 32'd0}},
      '{'{KIND_POLL, 32'd1000, 1'b0, 32'd50000, 32'd9, 1'b1, 1'b0}, 1'b1,
        '{PH_WAKING, ERR_ADV_FAIL, 20'd3000, 1'b0, 1'b0, 1'b0, 1'b0, LOG_NONE,
          32'd0, 32'd0}},
      '{'{KIND_POLL, 32'd1100, 1'b1, 32'd13225, 32'd77, 1'b1, 1'b0}, 1'b1,
        '{PH_WAKING, ERR_ADV_SILENT, 20'd3000, 1'b1, 1'b1, 1'b0, 1'b0, LOG_ADV,
          32'd13225, 32'd77}},
      '{'{KIND_POLL, 32'd1200, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0}, 1'b1,
        '{PH_WAKING, ERR_NONE, 20'd3000, 1'b1, 1'b0, 1'b0, 1'b0, LOG_ADV,
          32'hFFFF_FFFF, 32'hFFFF_FFFF}},
      '{'{KIND_STOP, 32'd1300, 1'b1, 32'd0, 32'd0, 1'b1, 1'b0}, 1'b1,
        '{PH_OFF, ERR_NONE, 20'd0, 1'b0, 1'b1, 1'b0, 1'b0, LOG_NONE, 32'd0, 32'd0}},
      '{'{KIND_START, 32'd2000, 1'b1, 32'd0, 32'd0, 1'b1, 1'b0}, 1'b1,
        '{PH_WAKING, ERR_NONE, 20'd0, 1'b0, 1'b0, 1'b0, 1'b0, LOG_NONE, 32'd0, 32'd0}},
      '{'{KIND_POLL, 32'd2000, 1'b1, 32'd13226, 32'd0, 1'b1, 1'b0}, 1'b0, '0},
      '{'{KIND_POLL, 32'd4999, 1'b1, 32'd0, 32'd0, 1'b1, 1'b0}, 1'b0, '0},
      '{'{KIND_POLL, 32'd5000, 1'b1, 32'd0, 32'd0, 1'b0, 1'b1}, 1'b1,
        '{PH_WAKING, ERR_LINK_FAIL, 20'd3000, 1'b0, 1'b1, 1'b1, 1'b0, LOG_NONE,
          32'd0, 32'd0}},
      '{'{KIND_POLL, 32'd5000, 1'b1, 32'd50000, 32'd1234, 1'b1, 1'b0}, 1'b0, '0},
      '{'{KIND_POLL, 32'd8000, 1'b1, 32'd0, 32'd0, 1'b1, 1'b0}, 1'b0, '0},
      '{'{KIND_POLL, 32'd9000, 1'b1, 32'd0, 32'd0, 1'b1, 1'b0}, 1'b0, '0},
      '{'{KIND_POLL, 32'd20000, 1'b1, 32'd0, 32'd0, 1'b1, 1'b0}, 1'b0, '0},
      '{'{KIND_HOLD_ON, 32'd20001, 1'b1, 32'd0, 32'd0, 1'b1, 1'b0}, 1'b0, '0},
      '{'{KIND_POLL, 32'd40000, 1'b1, 32'd0, 32'd0, 1'b1, 1'b0}, 1'b0, '0},
      '{'{KIND_HOLD_OFF, 32'd40001, 1'b1, 32'd0, 32'd0, 1'b1, 1'b0}, 1'b0, '0},
      '{'{KIND_POLL, 32'd40002, 1'b1, 32'd0, 32'd0, 1'b1, 1'b0}, 1'b0, '0},
      '{'{KIND_POLL, 32'd40003, 1'b1, 32'd0, 32'd0, 1'b1, 1'b0}, 1'b0, '0},
      '{'{KIND_POLL, 32'd40004, 1'b1, 32'd70000, 32'd4321, 1'b1, 1'b0}, 1'b0, '0},
      '{'{KIND_POLL, 32'd43004, 1'b1, 32'd0, 32'd0, 1'b1, 1'b0}, 1'b0, '0},
      '{'{KIND_POLL, 32'd44004, 1'b1, 32'd0, 32'd0, 1'b1, 1'b1}, 1'b0, '0},
      '{'{KIND_POLL, 32'd64004, 1'b1, 32'd0, 32'd0, 1'b1, 1'b0}, 1'b0, '0},
      '{'{KIND_STOP, 32'd64005, 1'b1, 32'd0, 32'd0, 1'b1, 1'b0}, 1'b0, '0}
   };

   function automatic logic [31:0] live_value(logic [31:0] raw, logic [31:0] dflt);
      return (raw != 0) ? raw : dflt;
   endfunction

   function automatic logic [31:0] phase_span();
      case (ph)
         PH_WAKING:   return live_value(cfg_adv, 32'(DFLT_ADVERTISE_TIME));
         PH_LOCKING:  return live_value(cfg_lock, 32'(DFLT_LOCK_CAP_TIME));
         PH_WATCHING: return live_value(cfg_watch, 32'(DFLT_WATCH_TIME));
         default:     return 32'd0;
      endcase
   endfunction

   // Apply one event to the phase machine and return the response it yields.
   function automatic result_type advance_duty_cycle(item_type e);
      result_type  r;
      logic [31:0] adv_len, safe_len, min_bytes, len, el, left, since, safe_left;
      bit          due;
      r         = '0;
      adv_len   = live_value(cfg_adv, 32'(DFLT_ADVERTISE_TIME));
      safe_len  = live_value(cfg_safe, 32'(DFLT_SAFE_DEADLINE));
      min_bytes = live_value(cfg_min, 32'(DFLT_MIN_RADIO_BYTES));
      case (e.kind)
         KIND_START: begin
            hold = 1'b0; adv_on = 1'b0; link_on = 1'b0;
            ph = PH_WAKING; ph_start = e.now_time - adv_len;
         end
         KIND_STOP: begin
            if (adv_on) begin r.adv_stop_strobe = 1'b1; adv_on = 1'b0; end
            if (link_on) begin r.link_stop_strobe = 1'b1; link_on = 1'b0; end
            ph = PH_OFF; hold = 1'b0;
         end
         KIND_HOLD_ON:  hold = 1'b1;
         KIND_HOLD_OFF: hold = 1'b0;
         KIND_POLL: if (ph != PH_OFF) begin
            el  = e.now_time - ph_start;
            due = (el >= phase_span());
            case (ph)
               PH_WAKING: begin
                  if (!adv_on) begin
                     if (!e.adv_start_ok) begin
                        err = ERR_ADV_FAIL;
                     end else begin
                        r.adv_start_strobe = 1'b1;
                        r.log_event  = LOG_ADV;
                        r.log_first  = e.adv_bytes_taken;
                        r.log_second = e.heap_remaining;
                        if (e.adv_bytes_taken < min_bytes) begin
                           err = ERR_ADV_SILENT; r.adv_stop_strobe = 1'b1;
                        end else begin
                           err = ERR_NONE; adv_on = 1'b1;
                        end
                     end
                     ph_start = e.now_time;
                  end else if (due) begin
                     // advert done: swap radios
                     r.adv_stop_strobe = 1'b1; adv_on = 1'b0; adv_stop_at = e.now_time;
                     r.link_start_strobe = 1'b1;
                     if (!e.link_start_ok) begin
                        err = ERR_LINK_FAIL; ph_start = e.now_time;
                     end else begin
                        err = ERR_NONE; link_on = 1'b1; lock_at = e.now_time;
                        r.log_event = LOG_LOCKING;
                        ph = PH_LOCKING; ph_start = e.now_time;
                     end
                  end
               end
               PH_LOCKING: if (e.peer_locked || due) begin
                  r.log_event  = e.peer_locked ? LOG_LOCKED : LOG_CAPPED;
                  r.log_first  = e.now_time - lock_at;
                  r.log_second = e.now_time - adv_stop_at;
                  watch_at = e.now_time;
                  ph = PH_WATCHING; ph_start = e.now_time;
               end
               PH_WATCHING: begin
                  if (hold) begin
                     ph_start = e.now_time;
                  end else begin
                     if (e.now_time - adv_stop_at >= safe_len) r.log_event = LOG_CLOSED_SAFE;
                     else if (due) r.log_event = LOG_CLOSED_WATCH;
                     if (r.log_event != LOG_NONE) begin
                        r.log_first  = e.now_time - watch_at;
                        r.log_second = e.now_time - adv_stop_at;
                        ph = PH_CLOSING; ph_start = e.now_time;
                     end
                  end
               end
               PH_CLOSING: begin
                  if (link_on) begin r.link_stop_strobe = 1'b1; link_on = 1'b0; end
                  ph = PH_WAKING; ph_start = e.now_time - adv_len;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      len  = phase_span();
      el   = e.now_time - ph_start;
      left = (el >= len) ? 32'd0 : len - el;
      if (ph == PH_WATCHING) begin
         since     = e.now_time - adv_stop_at;
         safe_left = (since >= safe_len) ? 32'd0 : safe_len - since;
         if (safe_left < left) left = safe_left;
      end
      r.phase_now  = ph;
      r.error_code = err;
      r.time_left  = left[19:0];
      return r;
   endfunction

   // Mostly polls with healthy radio outcomes; time steps scale to the phase.
   function automatic item_type next_random_event();
      item_type    e;
      int unsigned roll;
      logic [31:0] span, floor_bytes;
      span = phase_span();
      if (span == 0) span = live_value(cfg_adv, 32'(DFLT_ADVERTISE_TIME));
      floor_bytes = live_value(cfg_min, 32'(DFLT_MIN_RADIO_BYTES));
      roll = $urandom_range(0, 99);
      if (roll < 72) e.kind = KIND_POLL;
      else if (roll < 80) e.kind = KIND_START;
      else if (roll < 84) e.kind = KIND_STOP;
      else if (roll < 90) e.kind = KIND_HOLD_ON;
      else if (roll < 96) e.kind = KIND_HOLD_OFF;
      else e.kind = 3'($urandom_range(KIND_RESERVED_LO, KIND_RESERVED_HI));
      roll = $urandom_range(0, 99);
      if (roll < 2) ms_now = $urandom();
      else if (roll < 45) ms_now = ms_now + $urandom_range(0, span / 8 + 1);
      else if (roll < 85) ms_now = ms_now + $urandom_range(0, 2 * span + 1);
      e.now_time = ms_now;
      roll = $urandom_range(0, 99);
      if (roll < 10) e.adv_bytes_taken = $urandom_range(0, floor_bytes - 1);
      else if (roll < 35) e.adv_bytes_taken = $urandom_range(floor_bytes, floor_bytes + 2000);
      else e.adv_bytes_taken = $urandom();
      e.heap_remaining = $urandom();
      e.adv_start_ok   = ($urandom_range(0, 9) != 0);
      e.link_start_ok  = ($urandom_range(0, 9) != 0);
      e.peer_locked    = ($urandom_range(0, 2) == 0);
      return e;
   endfunction

   task automatic send_event(input item_type e, input bit has_want, input result_type want);
      result_type predicted;
      int         gap;
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
         gap = $urandom_range(1, 5);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid           <= 1'b1;
      req_kind            <= e.kind;
      req_now_time        <= e.now_time;
      req_adv_start_ok    <= e.adv_start_ok;
      req_adv_bytes_taken <= e.adv_bytes_taken;
      req_heap_remaining  <= e.heap_remaining;
      req_link_start_ok   <= e.link_start_ok;
      req_peer_locked     <= e.peer_locked;
      do @(posedge clock); while (req_stall);
      predicted = advance_duty_cycle(e);
      pending_results.push_back(has_want ? want : predicted);
      events_sent++;
   endtask

   task automatic poke_register(input logic [CSR_IDX_W-1:0] idx, input logic [19:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_ADVERTISE_TIME:  cfg_adv   = {12'd0, data};
         CSR_LOCK_CAP_TIME:   cfg_lock  = {12'd0, data};
         CSR_WATCH_TIME:      cfg_watch = {12'd0, data};
         CSR_SAFE_DEADLINE:   cfg_safe  = {12'd0, data};
         CSR_MIN_RADIO_BYTES: cfg_min   = {16'd0, data[15:0]};
         default: ;
      endcase
   endtask

   // Drain the block, then rewrite every register.
   task automatic apply_settings(input logic [19:0] adv_t, lock_t, watch_t, safe_t, min_b,
                                 input bit poke_spare);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      poke_register(CSR_ADVERTISE_TIME, adv_t);
      poke_register(CSR_LOCK_CAP_TIME, lock_t);
      poke_register(CSR_WATCH_TIME, watch_t);
      poke_register(CSR_SAFE_DEADLINE, safe_t);
      poke_register(CSR_MIN_RADIO_BYTES, min_b);
      if (poke_spare) poke_register(CSR_UNUSED_INDEX, 20'($urandom()));
      @(negedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
         mismatches++;
      end
   endfunction

   // receiver backpressure in short bursts, with calm stretches
   always @(negedge clock) begin
      if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (calm_left > 0) calm_left <= calm_left - 1;
         else if ($urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 5);
         else if ($urandom_range(0, 39) == 0) calm_left <= $urandom_range(20, 80);
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            log_seen[rsp_log_event]++;
            if (pending_results.size() == 0) begin
               $display("%0t ns: response transaction with nothing expected", $time);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               check_field("phase_now", 32'(want.phase_now), 32'(rsp_phase_now));
               check_field("error_code", 32'(want.error_code), 32'(rsp_error_code));
               check_field("time_left", 32'(want.time_left), 32'(rsp_time_left));
               check_field("adv_start_strobe", 32'(want.adv_start_strobe),
                           32'(rsp_adv_start_strobe));
               check_field("adv_stop_strobe", 32'(want.adv_stop_strobe),
                           32'(rsp_adv_stop_strobe));
               check_field("link_start_strobe", 32'(want.link_start_strobe),
                           32'(rsp_link_start_strobe));
               check_field("link_stop_strobe", 32'(want.link_stop_strobe),
                           32'(rsp_link_stop_strobe));
               check_field("log_event", 32'(want.log_event), 32'(rsp_log_event));
               check_field("log_first", want.log_first, rsp_log_first);
               check_field("log_second", want.log_second, rsp_log_second);
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("radio_wake_cycle_sequencer_unit_tb failed");
            $finish;
         end
      end
   end

   initial begin
      item_type e;
      int       p, n;
      req_valid           = 1'b0;
      req_kind            = KIND_POLL;
      req_now_time        = '0;
      req_adv_start_ok    = 1'b0;
      req_adv_bytes_taken = '0;
      req_heap_remaining  = '0;
      req_link_start_ok   = 1'b0;
      req_peer_locked     = 1'b0;
      csr_wr_en           = 1'b0;
      csr_index           = CSR_ADVERTISE_TIME;
      csr_wdata           = '0;
      reset               = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (n = 0; n < SCRIPT_LEN; n++) send_event(script[n].ev, script[n].has_want, script[n].want);

      for (p = 0; p < SETTINGS_RUNS; p++) begin
         case (p)
            1: apply_settings(LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX, 20'h0FFFF, 1'b0);
            2: apply_settings(20'd1, 20'd1, 20'd1, 20'd1, 20'd0, 1'b0);
            3: apply_settings(20'd0, 20'd0, 20'd0, 20'd0, 20'hF0000, 1'b0);
            4: apply_settings(20'($urandom_range(1, 60)), 20'($urandom_range(1, 60)),
                              20'($urandom_range(1, 60)), 20'($urandom_range(1, 120)),
                              20'($urandom()), 1'b1);
            5: apply_settings(20'($urandom_range(1, LEN_MAX)), 20'($urandom_range(1, LEN_MAX)),
                              20'($urandom_range(1, LEN_MAX)), 20'($urandom_range(1, LEN_MAX)),
                              20'($urandom_range(0, 16'hFFFF)), 1'b0);
            default: ;
         endcase
         // odd runs start just short of the counter wrap
         ms_now = p[0] ? 32'hFFFF_FFFF - $urandom_range(0, 2000000) : $urandom();
         quiet  = (p == SETTINGS_RUNS - 1);
         for (n = 0; n < EVENTS_PER_SETTING; n++) begin
            if (n % 40 == 0) gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
            e = next_random_event();
            send_event(e, 1'b0, '0);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      for (n = 0; n < IDLE_LIMIT && pending_results.size() != 0; n++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t ns: %0d responses never arrived", $time, pending_results.size());
         mismatches++;
      end
      $display("Covered %0d events under %0d register settings, %0d responses checked.",
               events_sent, settings_used, results_checked);
      $display("Logged: adv %0d, locking %0d, locked %0d, capped %0d, safe %0d, watch %0d.",
               log_seen[LOG_ADV], log_seen[LOG_LOCKING], log_seen[LOG_LOCKED],
               log_seen[LOG_CAPPED], log_seen[LOG_CLOSED_SAFE], log_seen[LOG_CLOSED_WATCH]);
      if (mismatches == 0) begin
         $display("radio_wake_cycle_sequencer_unit_tb passed");
      end else begin
         $display("radio_wake_cycle_sequencer_unit_tb failed");
      end
      $finish;
   end

endmodule
